@@ design/mpe_pkg.sv @@
package mpe_pkg;

    // matrix geometry
    localparam int MAX_SIZE = 8;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int DIM_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = ADDR_W + 1;

    // field and register widths
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 4;
    localparam int EXP_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP  = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT_READ,
        ST_OUT_SHOW
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_en;
        logic [ADDR_W-1:0] load_addr;
        logic              rd_en;
        logic              issue;
        logic              first;
        logic              last;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [DIM_W-1:0]  mid;
        logic [SIZE_W-1:0] n;
        logic              src;
        logic              ident;
        logic              diag;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic busy;
    } dp_stat_t;

    // size register value clamped to 1..MAX_SIZE
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (s > SIZE_W'(MAX_SIZE))
        begin
            r = SIZE_W'(MAX_SIZE);
        end
        return r;
    endfunction

    // row-major flat address
    function automatic logic [ADDR_W-1:0] flat_addr(
        input logic [DIM_W-1:0]  r,
        input logic [DIM_W-1:0]  c,
        input logic [SIZE_W-1:0] n
    );
        logic [DIM_W+SIZE_W-1:0] f;
        f = (DIM_W+SIZE_W)'(r) * (DIM_W+SIZE_W)'(n) + (DIM_W+SIZE_W)'(c);
        return f[ADDR_W-1:0];
    endfunction

endpackage

@@ design/matrix_power_engine_unit.sv @@
// compute: n*n load items, then, for an exponent above 1, (exponent-1) rounds of n*n*n
// multiply-accumulates each, done by the single multiply-accumulate unit fed from one read port per memory
// output: each result item is read, then presented and held while out_stall is high
// throughput: one input item per cycle during load; no input during compute/output
// reset: asynchronous active low; size and exponent registers return to 1,
// load count and control state clear; matrix memories are not cleared
module matrix_power_engine_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [mpe_pkg::DATA_W-1:0]     element_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mpe_pkg::DATA_W-1:0]     result_value,
    output logic                                  is_last,
    input  logic                                  cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mpe_pkg::CFG_W-1:0]             cfg_data
);

    logic [mpe_pkg::SIZE_W-1:0] size_reg;
    logic [mpe_pkg::EXP_W-1:0]  exp_reg;
    mpe_pkg::dp_cmd_t           cmd;
    mpe_pkg::dp_stat_t          stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= mpe_pkg::SIZE_W'(1);
            exp_reg  <= mpe_pkg::EXP_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpe_pkg::CFG_SIZE: size_reg <= cfg_data[mpe_pkg::SIZE_W-1:0];
                mpe_pkg::CFG_EXP:  exp_reg  <= cfg_data[mpe_pkg::EXP_W-1:0];
                default:           ;
            endcase
        end
    end

    mpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_last   (is_last),
        .size_cfg  (size_reg),
        .exp_cfg   (exp_reg),
        .cmd       (cmd),
        .stat      (stat)
    );

    mpe_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .element_value (element_value),
        .result_value  (result_value)
    );

endmodule

@@ design/mpe_ctrl.sv @@
module mpe_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      is_last,
    input  logic [mpe_pkg::SIZE_W-1:0] size_cfg,
    input  logic [mpe_pkg::EXP_W-1:0]  exp_cfg,
    output mpe_pkg::dp_cmd_t          cmd,
    input  mpe_pkg::dp_stat_t         stat
);

    mpe_pkg::state_t                 state_reg, state_next;
    logic [mpe_pkg::CNT_W-1:0]       load_cnt_reg, load_cnt_next;
    logic [mpe_pkg::DIM_W-1:0]       row_reg, row_next;
    logic [mpe_pkg::DIM_W-1:0]       col_reg, col_next;
    logic [mpe_pkg::DIM_W-1:0]       mid_reg, mid_next;
    logic [mpe_pkg::SIZE_W-1:0]      n_reg, n_next;
    logic [mpe_pkg::EXP_W-1:0]       exp_lat_reg, exp_lat_next;
    logic [mpe_pkg::EXP_W-1:0]       round_reg, round_next;
    logic                            src_reg, src_next;
    logic                            ident_reg, ident_next;

    logic [mpe_pkg::SIZE_W-1:0]      n_cur;
    logic [mpe_pkg::CNT_W-1:0]       total_cur;
    logic [mpe_pkg::CNT_W-1:0]       cnt_inc;
    logic [mpe_pkg::EXP_W-1:0]       round_inc;
    logic [mpe_pkg::SIZE_W-1:0]      n_last;
    logic                            row_end, col_end, mid_end;

    // size in force for the item being loaded
    assign n_cur     = mpe_pkg::eff_size(size_cfg);
    assign total_cur = mpe_pkg::CNT_W'(n_cur) * mpe_pkg::CNT_W'(n_cur);
    assign cnt_inc   = load_cnt_reg + mpe_pkg::CNT_W'(1);
    assign round_inc = round_reg + mpe_pkg::EXP_W'(1);

    // loop bounds for the latched size
    assign n_last  = n_reg - mpe_pkg::SIZE_W'(1);
    assign row_end = (mpe_pkg::SIZE_W'(row_reg) == n_last);
    assign col_end = (mpe_pkg::SIZE_W'(col_reg) == n_last);
    assign mid_end = (mpe_pkg::SIZE_W'(mid_reg) == n_last);

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mpe_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            mid_reg      <= '0;
            n_reg        <= mpe_pkg::SIZE_W'(1);
            exp_lat_reg  <= '0;
            round_reg    <= '0;
            src_reg      <= 1'b0;
            ident_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            mid_reg      <= mid_next;
            n_reg        <= n_next;
            exp_lat_reg  <= exp_lat_next;
            round_reg    <= round_next;
            src_reg      <= src_next;
            ident_reg    <= ident_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        mid_next      = mid_reg;
        n_next        = n_reg;
        exp_lat_next  = exp_lat_reg;
        round_next    = round_reg;
        src_next      = src_reg;
        ident_next    = ident_reg;

        in_stall  = 1'b1;
        out_valid = 1'b0;
        is_last   = 1'b0;

        cmd           = '0;
        cmd.load_addr = load_cnt_reg[mpe_pkg::ADDR_W-1:0];
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.mid       = mid_reg;
        cmd.n         = n_reg;
        cmd.src       = src_reg;
        cmd.ident     = ident_reg;
        cmd.diag      = (row_reg == col_reg);

        case (state_reg)
            mpe_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_en = 1'b1;
                    if (cnt_inc >= total_cur)
                    begin
                        // matrix complete: latch size and power
                        load_cnt_next = '0;
                        n_next        = n_cur;
                        exp_lat_next  = exp_cfg;
                        src_next      = 1'b0;
                        row_next      = '0;
                        col_next      = '0;
                        mid_next      = '0;
                        round_next    = mpe_pkg::EXP_W'(1);
                        ident_next    = (exp_cfg == '0);
                        if (exp_cfg > mpe_pkg::EXP_W'(1))
                        begin
                            state_next = mpe_pkg::ST_ISSUE;
                        end
                        else
                        begin
                            state_next = mpe_pkg::ST_OUT_READ;
                        end
                    end
                    else
                    begin
                        load_cnt_next = cnt_inc;
                    end
                end
            end

            mpe_pkg::ST_ISSUE:
            begin
                // one multiply-accumulate per cycle, k innermost
                cmd.rd_en = 1'b1;
                cmd.issue = 1'b1;
                cmd.first = (mid_reg == '0);
                cmd.last  = mid_end;
                if (mid_end)
                begin
                    mid_next = '0;
                    if (col_end)
                    begin
                        col_next = '0;
                        if (row_end)
                        begin
                            row_next   = '0;
                            state_next = mpe_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            row_next = row_reg + mpe_pkg::DIM_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + mpe_pkg::DIM_W'(1);
                    end
                end
                else
                begin
                    mid_next = mid_reg + mpe_pkg::DIM_W'(1);
                end
            end

            mpe_pkg::ST_DRAIN:
            begin
                // wait for the last writes, then swap banks
                if (!stat.busy)
                begin
                    round_next = round_inc;
                    src_next   = !src_reg;
                    if (round_inc < exp_lat_reg)
                    begin
                        state_next = mpe_pkg::ST_ISSUE;
                    end
                    else
                    begin
                        state_next = mpe_pkg::ST_OUT_READ;
                    end
                end
            end

            mpe_pkg::ST_OUT_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = mpe_pkg::ST_OUT_SHOW;
            end

            mpe_pkg::ST_OUT_SHOW:
            begin
                out_valid = 1'b1;
                is_last   = row_end && col_end;
                if (!out_stall)
                begin
                    if (row_end && col_end)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        state_next = mpe_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = mpe_pkg::ST_OUT_READ;
                        if (col_end)
                        begin
                            col_next = '0;
                            row_next = row_reg + mpe_pkg::DIM_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + mpe_pkg::DIM_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = mpe_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

@@ design/mpe_dpath.sv @@
module mpe_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpe_pkg::dp_cmd_t                  cmd,
    output mpe_pkg::dp_stat_t                 stat,
    input  logic signed [mpe_pkg::DATA_W-1:0] element_value,
    output logic signed [mpe_pkg::DATA_W-1:0] result_value
);

    logic [mpe_pkg::DATA_W-1:0] base_mem  [mpe_pkg::DEPTH];
    logic [mpe_pkg::DATA_W-1:0] bank0_mem [mpe_pkg::DEPTH];
    logic [mpe_pkg::DATA_W-1:0] bank1_mem [mpe_pkg::DEPTH];

    logic [mpe_pkg::ADDR_W-1:0] pa, ba, wa, rd_addr;
    logic [mpe_pkg::DATA_W-1:0] elem;

    logic [mpe_pkg::DATA_W-1:0] base_rd_reg, rd0_reg, rd1_reg;
    logic [mpe_pkg::DATA_W-1:0] a_sel, mul_c, acc_sum;

    logic                       s1_valid_reg, s2_valid_reg;
    logic                       s1_first_reg, s1_last_reg;
    logic                       s2_first_reg, s2_last_reg;
    logic [mpe_pkg::ADDR_W-1:0] s1_waddr_reg, s2_waddr_reg;
    logic [mpe_pkg::DATA_W-1:0] mul_reg, acc_reg;

    logic                       rwe;
    logic                       bank0_we, bank1_we;
    logic [mpe_pkg::ADDR_W-1:0] bank0_waddr;
    logic [mpe_pkg::DATA_W-1:0] bank0_wdata;

    // operand and target addresses
    assign pa      = mpe_pkg::flat_addr(cmd.row, cmd.mid, cmd.n);
    assign ba      = mpe_pkg::flat_addr(cmd.mid, cmd.col, cmd.n);
    assign wa      = mpe_pkg::flat_addr(cmd.row, cmd.col, cmd.n);
    assign rd_addr = cmd.issue ? pa : wa;
    assign elem    = $unsigned(element_value);

    // accumulate and write back to the bank not being read
    assign acc_sum     = s2_first_reg ? mul_reg : acc_reg + mul_reg;
    assign rwe         = s2_valid_reg && s2_last_reg;
    assign bank0_we    = cmd.load_en || (rwe && cmd.src);
    assign bank1_we    = rwe && !cmd.src;
    assign bank0_waddr = cmd.load_en ? cmd.load_addr : s2_waddr_reg;
    assign bank0_wdata = cmd.load_en ? elem : acc_sum;

    // loaded matrix
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            base_mem[cmd.load_addr] <= elem;
        end
        if (cmd.rd_en)
        begin
            base_rd_reg <= base_mem[ba];
        end
    end

    // product bank 0, also takes the load
    always_ff @(posedge clk)
    begin
        if (bank0_we)
        begin
            bank0_mem[bank0_waddr] <= bank0_wdata;
        end
        if (cmd.rd_en)
        begin
            rd0_reg <= bank0_mem[rd_addr];
        end
    end

    // product bank 1
    always_ff @(posedge clk)
    begin
        if (bank1_we)
        begin
            bank1_mem[s2_waddr_reg] <= acc_sum;
        end
        if (cmd.rd_en)
        begin
            rd1_reg <= bank1_mem[rd_addr];
        end
    end

    // current product operand
    assign a_sel = cmd.src ? rd1_reg : rd0_reg;
    assign mul_c = a_sel * base_rd_reg;

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline tags, product and accumulator
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_waddr_reg <= wa;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_waddr_reg <= s1_waddr_reg;
        mul_reg      <= mul_c;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign stat.busy = s1_valid_reg || s2_valid_reg;

    // identity for a zero power, otherwise the stored product
    assign result_value = cmd.ident ?
        $signed(mpe_pkg::DATA_W'(cmd.diag)) : $signed(a_sel);

endmodule
